// ===== sv/cfs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants of the complex frequency shifter.
// No dependencies; imported by the front end and the top level.
package cfs_pkg;

    localparam int CFS_SAMPLE_WIDTH     = 16;
    localparam int CFS_PHASOR_FRAC_BITS = 16;
    localparam int CFS_QUEUE_DEPTH      = 4;
    localparam int CFG_INDEX_WIDTH      = 1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_STEP_COS = 1'b0,
        REG_STEP_SIN = 1'b1
    } cfg_reg_t;

endpackage

// ===== sv/complex_frequency_shifter.sv =====
`timescale 1ns / 1ps
// The block accepts one complex sample per clock and returns it mixed with the conjugate
// of a running phasor; while the output is not stalled, a sustained rate of one sample per
// cycle is kept. That rate is set by the phasor recurrence in the front end, one rounded
// multiply-add step per accepted sample. An accepted sample passes the queue, the product
// stage and the output register; the queue of QUEUE_DEPTH requests lets the intake keep
// going while the output is stalled. The phasor starts at one with zero phase after reset
// and is not renormalized. Step registers should be written only while the block is idle.
// Top level: instantiates cfs_front, cfs_queue and cfs_back; depends on cfs_pkg.
module complex_frequency_shifter #(
    parameter int SAMPLE_WIDTH     = cfs_pkg::CFS_SAMPLE_WIDTH,
    parameter int PHASOR_FRAC_BITS = cfs_pkg::CFS_PHASOR_FRAC_BITS,
    parameter int QUEUE_DEPTH      = cfs_pkg::CFS_QUEUE_DEPTH
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic [cfs_pkg::CFG_INDEX_WIDTH-1:0]           cfg_index,
    input  logic [PHASOR_FRAC_BITS+1:0]                   cfg_data,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // Fields from bit 0: in_i, in_q, zero fill.
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]           s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // Fields from bit 0: out_i, out_q, zero fill.
    output logic [((2*SAMPLE_WIDTH+2+7)/8)*8-1:0]         m_tdata
);
    import cfs_pkg::*;

    localparam int EW    = 2 * SAMPLE_WIDTH + 2 * (PHASOR_FRAC_BITS + 2);
    localparam int OW    = SAMPLE_WIDTH + 1;
    localparam int OUT_W = ((2 * SAMPLE_WIDTH + 2 + 7) / 8) * 8;

    logic          push_valid;
    logic          push_ready;
    logic [EW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [EW-1:0] pop_data;
    logic [OW-1:0] out_i;
    logic [OW-1:0] out_q;

    cfs_front #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .PHASOR_FRAC_BITS (PHASOR_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata[2*SAMPLE_WIDTH-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    cfs_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    cfs_back #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .PHASOR_FRAC_BITS (PHASOR_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_i     (out_i),
        .out_q     (out_q)
    );

    assign m_tdata = OUT_W'({out_q, out_i});

endmodule

// ===== sv/cfs_front.sv =====
`timescale 1ns / 1ps
// Front end: step registers, running phasor and sample intake.
// Depends on cfs_pkg for the register indexes.
module cfs_front #(
    parameter int SAMPLE_WIDTH     = 16,
    parameter int PHASOR_FRAC_BITS = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic [cfs_pkg::CFG_INDEX_WIDTH-1:0]          cfg_index,
    input  logic [PHASOR_FRAC_BITS+1:0]                  cfg_data,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [2*SAMPLE_WIDTH-1:0]                    in_data,
    output logic                                         push_valid,
    input  logic                                         push_ready,
    output logic [2*SAMPLE_WIDTH+2*PHASOR_FRAC_BITS+3:0] push_data
);
    import cfs_pkg::*;

    localparam int PW  = PHASOR_FRAC_BITS + 2;
    localparam int SUW = 2 * PW + 2;
    localparam int SHW = SUW - PHASOR_FRAC_BITS;
    localparam logic signed [SUW-1:0] HALF = SUW'(1) << (PHASOR_FRAC_BITS - 1);
    localparam logic signed [PW-1:0]  ONE  = PW'(1) << PHASOR_FRAC_BITS;

    logic signed [PW-1:0]    step_cos_reg;
    logic signed [PW-1:0]    step_sin_reg;
    logic signed [PW-1:0]    phasor_cos_reg;
    logic signed [PW-1:0]    phasor_sin_reg;
    logic signed [PW-1:0]    phasor_cos_next;
    logic signed [PW-1:0]    phasor_sin_next;
    logic signed [2*PW-1:0]  p_cc;
    logic signed [2*PW-1:0]  p_ss;
    logic signed [2*PW-1:0]  p_sc;
    logic signed [2*PW-1:0]  p_cs;
    logic signed [SUW-1:0]   sum_cos;
    logic signed [SUW-1:0]   sum_sin;
    logic signed [SHW-1:0]   sh_cos;
    logic signed [SHW-1:0]   sh_sin;
    logic                    accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;
    assign push_data  = {phasor_sin_reg, phasor_cos_reg, in_data};

    always_comb
    begin
        p_cc    = phasor_cos_reg * step_cos_reg;
        p_ss    = phasor_sin_reg * step_sin_reg;
        p_sc    = phasor_sin_reg * step_cos_reg;
        p_cs    = phasor_cos_reg * step_sin_reg;
        sum_cos = SUW'(p_cc) - SUW'(p_ss) + HALF;
        sum_sin = SUW'(p_sc) + SUW'(p_cs) + HALF;
        sh_cos  = SHW'(sum_cos >>> PHASOR_FRAC_BITS);
        sh_sin  = SHW'(sum_sin >>> PHASOR_FRAC_BITS);
        if (sh_cos[SHW-1:PW-1] == {(SHW-PW+1){sh_cos[SHW-1]}})
        begin
            phasor_cos_next = sh_cos[PW-1:0];
        end
        else
        begin
            phasor_cos_next = {sh_cos[SHW-1], {(PW-1){~sh_cos[SHW-1]}}};
        end
        if (sh_sin[SHW-1:PW-1] == {(SHW-PW+1){sh_sin[SHW-1]}})
        begin
            phasor_sin_next = sh_sin[PW-1:0];
        end
        else
        begin
            phasor_sin_next = {sh_sin[SHW-1], {(PW-1){~sh_sin[SHW-1]}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cos_reg   <= ONE;
            step_sin_reg   <= '0;
            phasor_cos_reg <= ONE;
            phasor_sin_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_STEP_COS: step_cos_reg <= cfg_data;
                    REG_STEP_SIN: step_sin_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                phasor_cos_reg <= phasor_cos_next;
                phasor_sin_reg <= phasor_sin_next;
            end
        end
    end

endmodule

// ===== sv/cfs_queue.sv =====
`timescale 1ns / 1ps
// Short request queue between the front end and the mixer.
// No dependencies.
module cfs_queue #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/cfs_back.sv =====
`timescale 1ns / 1ps
// Mixer back end: product stage, then round, saturate and output register.
// No dependencies; fed by cfs_queue.
module cfs_back #(
    parameter int SAMPLE_WIDTH     = 16,
    parameter int PHASOR_FRAC_BITS = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         pop_valid,
    output logic                                         pop_ready,
    input  logic [2*SAMPLE_WIDTH+2*PHASOR_FRAC_BITS+3:0] pop_data,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [SAMPLE_WIDTH:0]                        out_i,
    output logic [SAMPLE_WIDTH:0]                        out_q
);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int PW  = PHASOR_FRAC_BITS + 2;
    localparam int OW  = SW + 1;
    localparam int PRW = SW + PW;
    localparam int SUW = PRW + 2;
    localparam int SHW = SUW - PHASOR_FRAC_BITS;
    localparam logic signed [SUW-1:0] HALF = SUW'(1) << (PHASOR_FRAC_BITS - 1);

    logic signed [SW-1:0]  s_i;
    logic signed [SW-1:0]  s_q;
    logic signed [PW-1:0]  ph_cos;
    logic signed [PW-1:0]  ph_sin;
    logic                  a_valid_reg;
    logic signed [PRW-1:0] p_ic_reg;
    logic signed [PRW-1:0] p_qs_reg;
    logic signed [PRW-1:0] p_qc_reg;
    logic signed [PRW-1:0] p_is_reg;
    logic                  out_valid_reg;
    logic [OW-1:0]         out_i_reg;
    logic [OW-1:0]         out_q_reg;
    logic [OW-1:0]         out_i_next;
    logic [OW-1:0]         out_q_next;
    logic signed [SUW-1:0] sum_i;
    logic signed [SUW-1:0] sum_q;
    logic signed [SHW-1:0] sh_i;
    logic signed [SHW-1:0] sh_q;
    logic                  b_en;
    logic                  a_en;

    assign s_i    = pop_data[SW-1:0];
    assign s_q    = pop_data[2*SW-1:SW];
    assign ph_cos = pop_data[2*SW+PW-1:2*SW];
    assign ph_sin = pop_data[2*SW+2*PW-1:2*SW+PW];

    assign b_en      = !out_valid_reg || out_ready;
    assign a_en      = !a_valid_reg || b_en;
    assign pop_ready = a_en;
    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;

    always_comb
    begin
        sum_i = SUW'(p_ic_reg) + SUW'(p_qs_reg) + HALF;
        sum_q = SUW'(p_qc_reg) - SUW'(p_is_reg) + HALF;
        sh_i  = SHW'(sum_i >>> PHASOR_FRAC_BITS);
        sh_q  = SHW'(sum_q >>> PHASOR_FRAC_BITS);
        if (sh_i[SHW-1:OW-1] == {(SHW-OW+1){sh_i[SHW-1]}})
        begin
            out_i_next = sh_i[OW-1:0];
        end
        else
        begin
            out_i_next = {sh_i[SHW-1], {(OW-1){~sh_i[SHW-1]}}};
        end
        if (sh_q[SHW-1:OW-1] == {(SHW-OW+1){sh_q[SHW-1]}})
        begin
            out_q_next = sh_q[OW-1:0];
        end
        else
        begin
            out_q_next = {sh_q[SHW-1], {(OW-1){~sh_q[SHW-1]}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && pop_valid)
        begin
            p_ic_reg <= s_i * ph_cos;
            p_qs_reg <= s_q * ph_sin;
            p_qc_reg <= s_q * ph_cos;
            p_is_reg <= s_i * ph_sin;
        end
        if (b_en && a_valid_reg)
        begin
            out_i_reg <= out_i_next;
            out_q_reg <= out_q_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= pop_valid;
            end
            if (b_en)
            begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

endmodule

// ===== sv/cfs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the complex frequency shifter, bound to the top level.
// Depends on cfs_pkg and on the port list of complex_frequency_shifter.
module cfs_checker #(
    parameter int SAMPLE_WIDTH     = cfs_pkg::CFS_SAMPLE_WIDTH,
    parameter int PHASOR_FRAC_BITS = cfs_pkg::CFS_PHASOR_FRAC_BITS,
    parameter int QUEUE_DEPTH      = cfs_pkg::CFS_QUEUE_DEPTH
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((2*SAMPLE_WIDTH+2+7)/8)*8-1:0] m_tdata
);
    localparam int CAP = QUEUE_DEPTH + 2;
    localparam int NW  = $clog2(CAP + 2);

    logic [NW-1:0] pending_reg;
    logic          in_acc;
    logic          out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // A result is only offered for a request that has been taken in.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pending_reg != '0))
        else $error("result offered with no request outstanding");

    // With every stage and queue slot occupied the intake must close.
    a_full_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg >= NW'(CAP)) |-> !s_tready)
        else $error("request accepted beyond block capacity");

    // A stalled result holds its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    // A request into an empty block is offered via queue, product and output stages.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && pending_reg == '0 && !m_tvalid) |-> ##3 m_tvalid)
        else $error("result did not appear after the pipeline delay");

endmodule

bind complex_frequency_shifter cfs_checker #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .PHASOR_FRAC_BITS (PHASOR_FRAC_BITS),
    .QUEUE_DEPTH      (QUEUE_DEPTH)
) u_cfs_checker (.*);

// ===== sim/tb_complex_frequency_shifter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for complex_frequency_shifter: predicts every mixed sample
// and the phasor recurrence in fixed point and compares each output request field by field.
// Depends on cfs_pkg and the RTL of the block; needs no files or arguments.
module tb_complex_frequency_shifter;
    import cfs_pkg::*;

    localparam int FRAC      = CFS_PHASOR_FRAC_BITS;
    localparam int OUT_W     = CFS_SAMPLE_WIDTH + 1;
    localparam int PHASOR_W  = CFS_PHASOR_FRAC_BITS + 2;
    localparam real TWO_PI   = 6.283185307179586;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_q;
        logic signed [OUT_W-1:0] out_i;
    } mixed_sample_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [PHASOR_W-1:0] cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [39:0]         m_tdata;

    logic signed [PHASOR_W-1:0] step_cos_q;
    logic signed [PHASOR_W-1:0] step_sin_q;
    logic signed [PHASOR_W-1:0] phasor_cos_q;
    logic signed [PHASOR_W-1:0] phasor_sin_q;
    mixed_sample_t              pending_mix[$];
    int                         mismatch_count = 0;
    bit                         steady_source = 1'b0;

    complex_frequency_shifter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    function automatic longint round_saturate(input longint acc, input int width);
        longint hi;
        longint lo;
        longint r;
        hi = (longint'(1) << (width - 1)) - 1;
        lo = -hi - 1;
        r  = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
        if (r > hi)
            r = hi;
        else if (r < lo)
            r = lo;
        return r;
    endfunction

    // Mixes one sample with the conjugate phasor, then rotates the phasor by the step.
    function automatic mixed_sample_t mix_and_rotate(input logic signed [15:0] si,
                                                     input logic signed [15:0] sq);
        mixed_sample_t res;
        longint        pc;
        longint        ps;
        longint        sc;
        longint        ss;
        pc = phasor_cos_q;
        ps = phasor_sin_q;
        sc = step_cos_q;
        ss = step_sin_q;
        res.out_i    = OUT_W'(round_saturate(longint'(si) * pc + longint'(sq) * ps, OUT_W));
        res.out_q    = OUT_W'(round_saturate(longint'(sq) * pc - longint'(si) * ps, OUT_W));
        phasor_cos_q = PHASOR_W'(round_saturate(pc * sc - ps * ss, PHASOR_W));
        phasor_sin_q = PHASOR_W'(round_saturate(ps * sc + pc * ss, PHASOR_W));
        return res;
    endfunction

    function automatic logic signed [PHASOR_W-1:0] to_q2_16(input real x);
        longint v;
        v = $rtoi(x >= 0.0 ? x * 65536.0 + 0.5 : x * 65536.0 - 0.5);
        if (v > 131071)
            v = 131071;
        else if (v < -131072)
            v = -131072;
        return PHASOR_W'(v);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_source || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'sh8000;
        if (r == 1)
            return 16'sh7fff;
        return 16'($urandom);
    endfunction

    // Entered and left just after a falling edge.
    task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {sq, si};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_mix.push_back(mix_and_rotate(si, sq));
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_mix.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_step(input logic signed [PHASOR_W-1:0] c,
                              input logic signed [PHASOR_W-1:0] s);
        cfg_we    <= 1'b1;
        cfg_index <= REG_STEP_COS;
        cfg_data  <= c;
        @(negedge clk);
        cfg_index <= REG_STEP_SIN;
        cfg_data  <= s;
        @(negedge clk);
        cfg_we <= 1'b0;
        step_cos_q = c;
        step_sin_q = s;
        @(negedge clk);
    endtask

    // Loads the conjugate of the phasor over its squared magnitude, when that exceeds 0.0625,
    // so one sample brings the phasor back close to one with zero phase.
    task automatic steer_phasor_to_one();
        real c;
        real s;
        real m2;
        c  = real'(phasor_cos_q) / 65536.0;
        s  = real'(phasor_sin_q) / 65536.0;
        m2 = c * c + s * s;
        if (m2 > 0.0625)
        begin
            write_step(to_q2_16(c / m2), to_q2_16(-s / m2));
            send_sample(pick_sample(), pick_sample());
            drain_results();
        end
    endtask

    task automatic test_unit_phasor();
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(-16'sd1, 16'sd1);
        drain_results();
    endtask

    task automatic test_saturation();
        write_step(18'sh1ffff, 18'sh1ffff);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000);
        drain_results();
        write_step(18'sh20000, 18'sh20000);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000);
        drain_results();
    endtask

    task automatic test_quarter_turn();
        steer_phasor_to_one();
        write_step(18'sh00000, 18'sh10000);
        repeat (4) send_sample(16'sh7fff, 16'sh0000);
        drain_results();
    endtask

    task automatic test_random_rotation();
        real theta;
        for (int phase = 0; phase < 8; phase++)
        begin
            steer_phasor_to_one();
            theta = real'($urandom_range(0, 65535)) * TWO_PI / 65536.0;
            write_step(to_q2_16($cos(theta)), to_q2_16($sin(theta)));
            steady_source = (phase % 3 == 1);
            for (int n = 0; n < 45; n++)
            begin
                if (phase == 3 && n == 20)
                    drain_results();
                send_sample(pick_sample(), pick_sample());
            end
            drain_results();
        end
        steady_source = 1'b0;
    endtask

    task automatic test_random_registers();
        for (int phase = 0; phase < 2; phase++)
        begin
            steer_phasor_to_one();
            write_step(PHASOR_W'($urandom), PHASOR_W'($urandom));
            repeat (12) send_sample(pick_sample(), pick_sample());
            drain_results();
        end
    endtask

    always @(posedge clk)
    begin
        mixed_sample_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_mix.size() == 0)
            begin
                $error("output request with no sample pending: out_i=%0d out_q=%0d",
                       $signed(m_tdata[16:0]), $signed(m_tdata[33:17]));
                mismatch_count++;
            end
            else
            begin
                want = pending_mix.pop_front();
                if (m_tdata[16:0] !== want.out_i)
                begin
                    $error("out_i: expected %0d, got %0d", want.out_i, $signed(m_tdata[16:0]));
                    mismatch_count++;
                end
                if (m_tdata[33:17] !== want.out_q)
                begin
                    $error("out_q: expected %0d, got %0d", want.out_q, $signed(m_tdata[33:17]));
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int seg;
        int kind;
        m_tready = 1'b0;
        forever
        begin
            kind = $urandom_range(0, 9);
            seg  = $urandom_range(1, 40);
            repeat (seg)
            begin
                @(negedge clk);
                if (kind < 3)
                    m_tready <= 1'b1;
                else if (kind == 9)
                    m_tready <= 1'b0;
                else
                    m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_STEP_COS;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        step_cos_q   = 18'sh10000;
        step_sin_q   = 18'sh00000;
        phasor_cos_q = 18'sh10000;
        phasor_sin_q = 18'sh00000;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_unit_phasor();
        test_saturation();
        test_quarter_turn();
        test_random_rotation();
        test_random_registers();
        drain_results();
        repeat (8) @(negedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== complex_frequency_shifter.f =====
sv/cfs_pkg.sv
sv/cfs_front.sv
sv/cfs_queue.sv
sv/cfs_back.sv
sv/complex_frequency_shifter.sv
sv/cfs_checker.sv
sim/tb_complex_frequency_shifter.sv
